// ----- rtl/core/lzd_pkg.sv -----
// lzd_pkg: shared types, field widths and default sizes for the lz77 token decompressor
// used by lz77_token_decompressor and the testbench; no dependencies
`default_nettype none

package lzd_pkg;

  // field widths of the token and result words
  localparam int OFFSET_W = 13;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 24;
  localparam int STATUS_W = 2;

  // default sizes
  localparam int DEF_WINDOW_SIZE      = 4096;
  localparam int DEF_MAX_MATCH_LENGTH = 63;

  // reset value of the output limit register
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_LIMIT  = 2'd1,
    STAT_OFFSET = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WRITE,
    S_LIT,
    S_STATUS
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/lzd_ram.sv -----
// lzd_ram: generic single-write, single-read synchronous ram with registered read data
// no package dependencies; read data holds its value while no read is issued
`default_nettype none

module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lz77_token_decompressor.sv -----
// lz77_token_decompressor: turns lz77 tokens into a byte stream through a history ram
// depends on lzd_pkg and lzd_ram
//
//   channel | signals                                               | direction
//   --------+-------------------------------------------------------+----------
//   in      | in_valid in_ready in_match_offset in_match_length     | input word
//           | in_next_byte in_end_of_stream                         |
//   out     | out_valid out_ready out_byte out_last out_status      | result word
//   cfg     | cfg_wr_en cfg_wr_data                                 | limit write
//
// one token word at a time: an accept step, then for each copied byte a ram read
// followed by write-back and output load, then the literal; an error or halted
// token goes from the accept step straight to the status word.
// the registered history ram read splits each copy into a read and a write step.
// a full output register that is not taken stalls the sequencer in place.
// synchronous active-low reset; the history ram needs no clearing.
`default_nettype none

module lz77_token_decompressor
  import lzd_pkg::*;
#(
  parameter int WINDOW_SIZE      = lzd_pkg::DEF_WINDOW_SIZE,
  parameter int MAX_MATCH_LENGTH = lzd_pkg::DEF_MAX_MATCH_LENGTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // token input
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lzd_pkg::OFFSET_W-1:0]  in_match_offset,
  input  wire logic [lzd_pkg::LEN_W-1:0]     in_match_length,
  input  wire logic [lzd_pkg::BYTE_W-1:0]    in_next_byte,
  input  wire logic                          in_end_of_stream,
  // result output
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [lzd_pkg::BYTE_W-1:0]    out_byte,
  output logic                               out_last,
  output logic      [lzd_pkg::STATUS_W-1:0]  out_status,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [lzd_pkg::LIMIT_W-1:0]   cfg_wr_data
);

  localparam int AW = $clog2(WINDOW_SIZE);
  // signed work width for address and window compares
  localparam int SW = ((AW + 1 > OFFSET_W) ? AW + 1 : OFFSET_W) + 1;
  localparam logic [SW-1:0]    WinSize  = SW'(WINDOW_SIZE);
  localparam logic [AW-1:0]    WinLast  = AW'(WINDOW_SIZE - 1);
  localparam logic [LEN_W-1:0] LenClamp = LEN_W'(MAX_MATCH_LENGTH);

  // control state
  state_t               state_r,   state_nxt;
  status_t              halt_r,    halt_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic [LIMIT_W-1:0]   bp_r,      bp_nxt;
  logic [AW-1:0]        wp_r,      wp_nxt;
  logic                 ovalid_r,  ovalid_nxt;

  // token context
  logic [AW-1:0]        rd_ptr_r,  rd_ptr_nxt;
  logic [LEN_W-1:0]     cnt_r,     cnt_nxt;
  logic [BYTE_W-1:0]    lit_r,     lit_nxt;
  logic                 eos_r,     eos_nxt;
  status_t              code_r,    code_nxt;

  // output word payload
  logic [BYTE_W-1:0]    obyte_r,   obyte_nxt;
  logic                 olast_r,   olast_nxt;
  status_t              ostat_r,   ostat_nxt;

  // ram port
  logic                 ram_we;
  logic                 ram_re;
  logic [BYTE_W-1:0]    ram_wdata;
  logic [BYTE_W-1:0]    ram_rdata;

  // token decode
  logic [LEN_W-1:0]     len_cl;
  logic [LIMIT_W:0]     need;
  logic                 cap_fail;
  logic                 off_fail;
  logic [SW-1:0]        diff;
  logic [SW-1:0]        src_wide;
  logic [AW-1:0]        src_addr;
  logic                 out_free;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == WinLast) ? '0 : p + 1'b1;
  endfunction

  // history window
  lzd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_SIZE)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // length clamp, capacity and offset checks, copy source address
  always_comb begin
    len_cl   = (in_match_length > LenClamp) ? LenClamp : in_match_length;
    need     = {1'b0, bp_r} + (LIMIT_W + 1)'(len_cl) + (LIMIT_W + 1)'(1);
    cap_fail = need > {1'b0, limit_r};
    off_fail = (len_cl != '0) &&
               ((in_match_offset == '0) ||
                (LIMIT_W'(in_match_offset) > bp_r) ||
                (SW'(in_match_offset) > WinSize));
    diff     = SW'(wp_r) - SW'(in_match_offset);
    src_wide = diff[SW-1] ? diff + WinSize : diff;
    src_addr = src_wide[AW-1:0];
  end

  assign out_free = !ovalid_r || out_ready;

  // sequencer: next state, ram control and output load
  always_comb begin
    state_nxt  = state_r;
    halt_nxt   = halt_r;
    bp_nxt     = bp_r;
    wp_nxt     = wp_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    lit_nxt    = lit_r;
    eos_nxt    = eos_r;
    code_nxt   = code_r;
    ovalid_nxt = ovalid_r && !out_ready;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    ostat_nxt  = ostat_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_wdata  = lit_r;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          lit_nxt    = in_next_byte;
          eos_nxt    = in_end_of_stream;
          cnt_nxt    = len_cl;
          rd_ptr_nxt = src_addr;
          if (halt_r != STAT_OK) begin
            code_nxt  = halt_r;
            state_nxt = S_STATUS;
          end else if (cap_fail) begin
            code_nxt  = STAT_LIMIT;
            halt_nxt  = STAT_LIMIT;
            state_nxt = S_STATUS;
          end else if (off_fail) begin
            code_nxt  = STAT_OFFSET;
            halt_nxt  = STAT_OFFSET;
            state_nxt = S_STATUS;
          end else if (len_cl == '0) begin
            state_nxt = S_LIT;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        ram_re     = 1'b1;
        rd_ptr_nxt = ptr_inc(rd_ptr_r);
        state_nxt  = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata;
          wp_nxt     = ptr_inc(wp_r);
          bp_nxt     = bp_r + 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
          ovalid_nxt = 1'b1;
          obyte_nxt  = ram_rdata;
          olast_nxt  = 1'b0;
          ostat_nxt  = STAT_OK;
          state_nxt  = (cnt_r == LEN_W'(1)) ? S_LIT : S_READ;
        end
      end
      S_LIT: begin
        if (out_free) begin
          ram_we     = 1'b1;
          wp_nxt     = ptr_inc(wp_r);
          bp_nxt     = eos_r ? '0 : bp_r + 1'b1;
          if (eos_r) begin
            halt_nxt = STAT_OK;
          end
          ovalid_nxt = 1'b1;
          obyte_nxt  = lit_r;
          olast_nxt  = 1'b1;
          ostat_nxt  = STAT_OK;
          state_nxt  = S_IDLE;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          if (eos_r) begin
            bp_nxt   = '0;
            halt_nxt = STAT_OK;
          end
          ovalid_nxt = 1'b1;
          obyte_nxt  = '0;
          olast_nxt  = 1'b1;
          ostat_nxt  = code_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      halt_r   <= STAT_OK;
      limit_r  <= LIMIT_RESET;
      bp_r     <= '0;
      wp_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      halt_r   <= halt_nxt;
      bp_r     <= bp_nxt;
      wp_r     <= wp_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // token context and output payload
  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    cnt_r    <= cnt_nxt;
    lit_r    <= lit_nxt;
    eos_r    <= eos_nxt;
    code_r   <= code_nxt;
    obyte_r  <= obyte_nxt;
    olast_r  <= olast_nxt;
    ostat_r  <= ostat_nxt;
  end

  assign out_valid  = ovalid_r;
  assign out_byte   = obyte_r;
  assign out_last   = olast_r;
  assign out_status = ostat_r;

  // a status word is always the last word of its token
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_last))
    else $error("status word without last");

  // a token taken while halted goes straight to the status step
  a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && halt_r != STAT_OK) |=> state_r == S_STATUS)
    else $error("halted token did not produce a status word");

  // history writes only come with an output load
  a_write_out: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (out_valid && out_status == STAT_OK && wp_r == ptr_inc($past(wp_r))))
    else $error("history write without matching output word");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench: self-checking bench for lz77_token_decompressor, with a token-level
// predictor of the history window, the output limit and the halt status
// depends on lzd_pkg and the lz77_token_decompressor rtl
`default_nettype none

module testbench;
  import lzd_pkg::*;

  localparam int WINDOW    = DEF_WINDOW_SIZE;
  localparam int MAX_MATCH = DEF_MAX_MATCH_LENGTH;
  localparam int PTR_W     = $clog2(WINDOW);
  localparam int QUIET_MAX = 2000;
  localparam int SETTLE    = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_last;
    status_t           status;
  } result_t;

  // clock, reset and dut inputs, all known from time zero
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic [OFFSET_W-1:0] in_match_offset = '0;
  logic [LEN_W-1:0]    in_match_length = '0;
  logic [BYTE_W-1:0]   in_next_byte = '0;
  logic                in_end_of_stream = 1'b0;
  logic                out_ready = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wr_data = '0;

  logic                in_ready;
  logic                out_valid;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last;
  logic [STATUS_W-1:0] out_status;

  // predictor state
  logic [BYTE_W-1:0]  hist_mem [0:WINDOW-1];
  logic [PTR_W-1:0]   wr_ptr = '0;
  logic [LIMIT_W-1:0] bytes_done = '0;
  status_t            halt_code = STAT_OK;
  logic [LIMIT_W-1:0] out_limit = LIMIT_RESET;
  result_t            pending_results[$];

  // bench bookkeeping
  bit      allow_idle = 1'b1;
  int      stall_left = 0;
  int      quiet_cycles = 0;
  int      fail_count = 0;
  int      token_count = 0;
  int      result_count = 0;
  int      limit_hits = 0;
  int      offset_hits = 0;
  result_t head_word;

  lz77_token_decompressor u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_match_offset  (in_match_offset),
    .in_match_length  (in_match_length),
    .in_next_byte     (in_next_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor: write one produced byte into the window and expect it
  function automatic void emit_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    hist_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    bytes_done = bytes_done + 1'b1;
    pending_results.push_back('{data: b, is_last: is_last, status: STAT_OK});
  endfunction

  // predictor: expected result words of one accepted token
  function automatic void decode_token(input logic [OFFSET_W-1:0] off,
                                       input logic [LEN_W-1:0] len,
                                       input logic [BYTE_W-1:0] lit,
                                       input logic eos);
    int unsigned count;
    logic [PTR_W-1:0] src;
    count = 32'(len);
    if (count > MAX_MATCH) count = MAX_MATCH;
    if (halt_code != STAT_OK) begin
      pending_results.push_back('{data: '0, is_last: 1'b1, status: halt_code});
    end else if (32'(bytes_done) + count + 1 > 32'(out_limit)) begin
      halt_code = STAT_LIMIT;
      pending_results.push_back('{data: '0, is_last: 1'b1, status: STAT_LIMIT});
    end else if (count > 0 && (off == 0 || off > bytes_done || off > WINDOW)) begin
      halt_code = STAT_OFFSET;
      pending_results.push_back('{data: '0, is_last: 1'b1, status: STAT_OFFSET});
    end else begin
      // overlapping copies read bytes written earlier in this same loop
      for (int i = 0; i < count; i++) begin
        src = wr_ptr - off[PTR_W-1:0];
        emit_byte(hist_mem[src], 1'b0);
      end
      emit_byte(lit, 1'b1);
    end
    if (eos) begin
      bytes_done = '0;
      halt_code = STAT_OK;
    end
  endfunction

  // send one token word, with an optional idle burst first
  task automatic send_token(input logic [OFFSET_W-1:0] off, input logic [LEN_W-1:0] len,
                            input logic [BYTE_W-1:0] lit, input logic eos);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_match_offset  <= off;
    in_match_length  <= len;
    in_next_byte     <= lit;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_token(off, len, lit, eos);
    token_count++;
  endtask

  // stop sending and let every expected word come out
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the output limit while the block is idle
  task automatic write_output_limit(input logic [LIMIT_W-1:0] value);
    wait_until_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    out_limit = value;
    cfg_wr_en <= 1'b0;
  endtask

  // literal-only tokens with field extremes; offset is ignored at length zero
  task automatic test_literals();
    write_output_limit(LIMIT_RESET);
    send_token(13'h0000, 6'd0, 8'h00, 1'b0);
    send_token(13'h1fff, 6'd0, 8'hff, 1'b0);
    send_token(13'h0aaa, 6'd0, 8'h55, 1'b0);
    send_token(13'h1555, 6'd0, 8'haa, 1'b1);
  endtask

  // copies: overlapping run, short distance, offset equal to bytes produced
  task automatic test_copies();
    send_token(13'd0, 6'd0, 8'h11, 1'b0);
    send_token(13'd1, 6'd63, 8'h22, 1'b0);
    send_token(13'd2, 6'd5, 8'h33, 1'b0);
    send_token(13'(bytes_done), 6'd10, 8'h44, 1'b0);
    send_token(13'd3, 6'd1, 8'h5a, 1'b1);
  endtask

  // bad offsets halt the block until end of stream
  task automatic test_offset_errors();
    send_token(13'd0, 6'd0, 8'h01, 1'b0);
    send_token(13'd0, 6'd4, 8'h02, 1'b0);
    send_token(13'd1, 6'd0, 8'h03, 1'b0);
    send_token(13'd5, 6'd2, 8'h04, 1'b1);
    send_token(13'd0, 6'd0, 8'h05, 1'b0);
    send_token(13'd2, 6'd3, 8'h06, 1'b1);
    send_token(13'd0, 6'd0, 8'h07, 1'b0);
    send_token(13'd1, 6'd2, 8'h08, 1'b1);
  endtask

  // output limit: exact fit, overflow, zero limit, capacity checked before offset
  task automatic test_limits();
    write_output_limit(24'd3);
    send_token(13'd0, 6'd0, 8'hc1, 1'b0);
    send_token(13'd1, 6'd1, 8'hc2, 1'b0);
    send_token(13'd0, 6'd0, 8'hc3, 1'b0);
    send_token(13'd0, 6'd0, 8'hc4, 1'b1);
    write_output_limit(24'd0);
    send_token(13'd0, 6'd0, 8'hc5, 1'b0);
    send_token(13'd0, 6'd0, 8'hc6, 1'b1);
    write_output_limit(24'd1);
    send_token(13'd0, 6'd0, 8'hc7, 1'b0);
    send_token(13'd0, 6'd0, 8'hc8, 1'b1);
    send_token(13'd0, 6'd5, 8'hc9, 1'b1);
    write_output_limit(LIMIT_RESET);
  endtask

  // fill past the window, then copy from exactly one window back and one beyond
  task automatic test_window_wrap();
    int unsigned span;
    send_token(13'd0, 6'd0, 8'($urandom), 1'b0);
    while (bytes_done <= WINDOW) begin
      span = (bytes_done > WINDOW) ? WINDOW : bytes_done;
      send_token(13'($urandom_range(1, span)), 6'd63, 8'($urandom), 1'b0);
    end
    send_token(13'(WINDOW), 6'd5, 8'h77, 1'b0);
    send_token(13'(WINDOW + 1), 6'd1, 8'h78, 1'b0);
    send_token(13'd0, 6'd0, 8'h79, 1'b1);
  endtask

  // mostly well-formed streams with random content, some noise and bad tokens
  task automatic random_token();
    logic [OFFSET_W-1:0] off;
    logic [LEN_W-1:0]    len;
    logic [BYTE_W-1:0]   lit;
    logic                eos;
    int unsigned         span;
    int                  pick;
    pick = $urandom_range(0, 99);
    lit  = BYTE_W'($urandom);
    eos  = (halt_code != STAT_OK) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 9) == 0);
    span = (bytes_done > WINDOW) ? WINDOW : bytes_done;
    if (pick < 10) begin
      off = OFFSET_W'($urandom);
      len = LEN_W'($urandom);
    end else if (span == 0 || pick < 25) begin
      off = OFFSET_W'($urandom);
      len = '0;
    end else begin
      off = OFFSET_W'($urandom_range(1, span));
      len = (pick < 35) ? LEN_W'($urandom_range(32, 63)) : LEN_W'($urandom_range(1, 8));
    end
    send_token(off, len, lit, eos);
  endtask

  task automatic test_random();
    logic [LIMIT_W-1:0] lim;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: lim = LIMIT_RESET;
        1: lim = LIMIT_W'($urandom_range(40, 400));
        default: lim = LIMIT_W'($urandom_range(1, 60));
      endcase
      write_output_limit(lim);
      // a stretch without idling in the middle, and none in the final phase
      allow_idle = (phase != 2 && phase != 5);
      repeat (13) random_token();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte %h last %b status %0d",
                 $time, out_byte, out_last, out_status);
        fail_count++;
      end else begin
        head_word = pending_results.pop_front();
        result_count++;
        if (out_status == STAT_LIMIT) limit_hits++;
        if (out_status == STAT_OFFSET) offset_hits++;
        if (out_byte !== head_word.data) begin
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, head_word.data, out_byte);
          fail_count++;
        end
        if (out_last !== head_word.is_last) begin
          $display("%0t: out_last mismatch: expected %b, actual %b",
                   $time, head_word.is_last, out_last);
          fail_count++;
        end
        if (out_status !== head_word.status) begin
          $display("%0t: out_status mismatch: expected %0d, actual %0d",
                   $time, head_word.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (!allow_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_literals();
    test_copies();
    test_offset_errors();
    test_limits();
    test_window_wrap();
    test_random();
    wait_until_drained();
    repeat (SETTLE) @(posedge clk);
    $display("run covered %0d tokens and %0d result words (%0d limit, %0d offset status)",
             token_count, result_count, limit_hits, offset_hits);
    $display("limits 0, 1, 3, random and max; overlapping copies and a full window wrap");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
